/* hdl/nlbh_pkg.sv */
// Package with shared types, codes and hash helpers for the line and block hasher.
`default_nettype none
package nlbh_pkg;

	localparam int unsigned HashW  = 64;
	localparam int unsigned CountW = 24;

	localparam logic [HashW-1:0]  HASH_SEED = 64'd5381;
	localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
	localparam logic [CountW-1:0] MIN_ALNUM_RESET = 24'd20;
	localparam logic [7:0]        SPACE_CHAR = 8'h20;

	// Operation codes of an input request.
	localparam logic [1:0] OP_BYTE      = 2'd0;
	localparam logic [1:0] OP_LINE_END  = 2'd1;
	localparam logic [1:0] OP_BLOCK_END = 2'd2;

	// Whitespace handling modes.
	localparam logic [1:0] MODE_KEEP     = 2'd0;
	localparam logic [1:0] MODE_DROP_ALL = 2'd1;
	localparam logic [1:0] MODE_COLLAPSE = 2'd2;
	localparam logic [1:0] MODE_TRAILING = 2'd3;

	// Configuration register indexes.
	localparam logic REG_SPACE_MODE = 1'b0;
	localparam logic REG_MIN_ALNUM  = 1'b1;

	// One registered input request as seen by the processing units.
	typedef struct packed {
		logic       valid;
		logic [1:0] operation;
		logic [7:0] text_byte;
	} step_t;

	typedef struct packed {
		logic [HashW-1:0]  line_digest;
		logic [HashW-1:0]  block_hash;
		logic [CountW-1:0] alnum_total;
		logic              meets_minimum;
		logic              block_done;
	} result_t;

	function automatic logic [HashW-1:0] djb2_mix(input logic [HashW-1:0] h,
		input logic [HashW-1:0] v);
		return (h << 5) + h + v;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage
`default_nettype wire

/* hdl/nlbh_if.sv */
// Valid/ready channel interfaces for text requests and hash results.
`default_nettype none
interface nlbh_text_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] text_byte;

	modport source (output valid, output operation, output text_byte, input ready);
	modport sink (input valid, input operation, input text_byte, output ready);
endinterface

interface nlbh_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] line_digest;
	logic [63:0] block_hash;
	logic [23:0] alnum_total;
	logic        meets_minimum;
	logic        block_done;

	modport source (output valid, output line_digest, output block_hash, output alnum_total,
		output meets_minimum, output block_done, input ready);
	modport sink (input valid, input line_digest, input block_hash, input alnum_total,
		input meets_minimum, input block_done, output ready);
endinterface
`default_nettype wire

/* hdl/nlbh_line_unit.sv */
// Per-line hash state with whitespace normalization.
`default_nettype none
module nlbh_line_unit
	import nlbh_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire step_t            step,
	input  wire logic [1:0]       space_mode,
	output logic      [HashW-1:0] line_digest
);

	logic [HashW-1:0] running_q;
	logic [HashW-1:0] kept_q;
	logic             last_space_q;
	logic [HashW-1:0] running_next;
	logic [HashW-1:0] mix_byte;
	logic [HashW-1:0] mix_space;
	logic             ws;

	always_comb begin
		ws        = is_space(step.text_byte);
		mix_byte  = djb2_mix(running_q, {{(HashW-8){1'b0}}, step.text_byte});
		mix_space = djb2_mix(running_q, {{(HashW-8){1'b0}}, SPACE_CHAR});
		running_next = mix_byte;
		case (space_mode)
			MODE_DROP_ALL: begin
				if (ws) running_next = running_q;
			end
			MODE_COLLAPSE: begin
				if (ws) running_next = last_space_q ? running_q : mix_space;
			end
			default: running_next = mix_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= HASH_SEED;
			kept_q       <= HASH_SEED;
			last_space_q <= 1'b0;
		end else if (step.valid) begin
			if (step.operation == OP_BYTE) begin
				running_q    <= running_next;
				last_space_q <= ws;
				if (!ws) kept_q <= running_next;
			end else if (step.operation == OP_LINE_END || step.operation == OP_BLOCK_END) begin
				running_q    <= HASH_SEED;
				kept_q       <= HASH_SEED;
				last_space_q <= 1'b0;
			end
		end
	end

	// Trailing mode reports the hash as it stood after the last non-space byte.
	assign line_digest = (space_mode == MODE_TRAILING) ? kept_q : running_q;

endmodule
`default_nettype wire

/* hdl/nlbh_block_unit.sv */
// Block hash and alphanumeric count, forming the result of each line end.
`default_nettype none
module nlbh_block_unit
	import nlbh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire step_t             step,
	input  wire logic [HashW-1:0]  line_digest,
	input  wire logic [CountW-1:0] min_alnum,
	output result_t                result
);

	logic [HashW-1:0]  block_q;
	logic [CountW-1:0] count_q;
	logic [HashW-1:0]  block_next;

	assign block_next = djb2_mix(block_q, line_digest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= HASH_SEED;
			count_q <= '0;
		end else if (step.valid) begin
			case (step.operation)
				OP_BYTE: begin
					if (is_alnum(step.text_byte) && count_q != COUNT_MAX)
						count_q <= count_q + 1'b1;
				end
				OP_LINE_END: begin
					block_q <= block_next;
				end
				OP_BLOCK_END: begin
					block_q <= HASH_SEED;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.line_digest   = line_digest;
		result.block_hash    = block_next;
		result.alnum_total   = count_q;
		result.meets_minimum = (count_q >= min_alnum);
		result.block_done    = (step.operation == OP_BLOCK_END);
	end

endmodule
`default_nettype wire

/* hdl/normalized_line_block_hash.sv */
// Top level of the normalized line and block hasher.
//
// Text arrives on text_chan one request per ready cycle: a byte of a line, an end
// of line, or an end of line that also closes the block. Each line is hashed
// with DJB2 after whitespace normalization chosen by the space_mode register,
// and each line hash is folded into a running block hash. Every end of line
// produces one result on result_chan; byte requests produce none.
//
// Requests are first captured in an input register, then the line and block
// units update their state and form the result, which lands in the output
// register. A result is valid once its line end has passed from the input
// register into the output register, and the block sustains one request per
// cycle while no line end waits in the input register for the output register.
//
// When the receiver stalls, the output register holds its result; byte
// requests keep flowing through, and only a line end that finds the output
// register still full waits in the input register. Reset clears both hashes
// to the seed, the count to zero, space_mode to keep-all and min_alnum to 20.
// Configuration writes on cfg_we/cfg_index/cfg_data are meant for idle time.
`default_nettype none
module normalized_line_block_hash
	import nlbh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	nlbh_text_if.sink        text_chan,
	nlbh_result_if.source    result_chan,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data
);

	logic [1:0]        space_mode_q;
	logic [CountW-1:0] min_alnum_q;

	// Input register.
	logic       valid_s1;
	logic [1:0] operation_s1;
	logic [7:0] text_byte_s1;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	step_t            step;
	logic             has_result;
	logic             out_free;
	logic             advance;
	logic [HashW-1:0] line_digest;
	result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_mode_q <= MODE_KEEP;
			min_alnum_q  <= MIN_ALNUM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SPACE_MODE) space_mode_q <= cfg_data[1:0];
			else min_alnum_q <= cfg_data[CountW-1:0];
		end
	end

	// A registered request moves on unless it needs the output register and
	// that register is still holding an untaken result.
	assign has_result = (operation_s1 == OP_LINE_END) || (operation_s1 == OP_BLOCK_END);
	assign out_free   = !out_valid_q || result_chan.ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign text_chan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_chan.ready) begin
			valid_s1 <= text_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_chan.ready && text_chan.valid) begin
			operation_s1 <= text_chan.operation;
			text_byte_s1 <= text_chan.text_byte;
		end
	end

	always_comb begin
		step.valid     = advance;
		step.operation = operation_s1;
		step.text_byte = text_byte_s1;
	end

	nlbh_line_unit u_line (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.space_mode  (space_mode_q),
		.line_digest (line_digest)
	);

	nlbh_block_unit u_block (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.line_digest (line_digest),
		.min_alnum   (min_alnum_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) out_q <= result;
	end

	assign result_chan.valid         = out_valid_q;
	assign result_chan.line_digest   = out_q.line_digest;
	assign result_chan.block_hash    = out_q.block_hash;
	assign result_chan.alnum_total   = out_q.alnum_total;
	assign result_chan.meets_minimum = out_q.meets_minimum;
	assign result_chan.block_done    = out_q.block_done;

endmodule
`default_nettype wire

/* tb/sv/normalized_line_block_hash_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the normalized line and block hasher.

// Tracks the hasher's line and block state and holds the results that
// the block still owes.
class line_digest_tracker;
	logic [1:0]  space_mode;
	logic [23:0] min_alnum;

	logic [63:0] line_acc;
	logic [63:0] kept_acc;
	logic        prev_blank;
	logic [63:0] block_acc;
	logic [23:0] alnum_count;

	nlbh_pkg::result_t due_hashes[$];
	int mismatch_count;

	function new();
		space_mode = nlbh_pkg::MODE_KEEP;
		min_alnum = 24'd20;
		clear_line();
		clear_block();
		mismatch_count = 0;
	endfunction

	function void clear_line();
		line_acc = 64'd5381;
		kept_acc = 64'd5381;
		prev_blank = 1'b0;
	endfunction

	function void clear_block();
		block_acc = 64'd5381;
		alnum_count = '0;
	endfunction

	function logic [63:0] times33_plus(input logic [63:0] h, input logic [63:0] v);
		return h * 64'd33 + v;
	endfunction

	function bit is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function bit is_word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function void set_register(input logic index, input logic [23:0] data);
		if (index == nlbh_pkg::REG_SPACE_MODE)
			space_mode = data[1:0];
		else
			min_alnum = data;
	endfunction

	function int pending();
		return due_hashes.size();
	endfunction

	function void note_request(input logic [1:0] op, input logic [7:0] c);
		nlbh_pkg::result_t due;
		bit blank;
		blank = is_blank(c);
		case (op)
			nlbh_pkg::OP_BYTE: begin
				if (is_word_char(c) && alnum_count != 24'hFFFFFF)
					alnum_count++;
				case (space_mode)
					nlbh_pkg::MODE_DROP_ALL: begin
						if (!blank)
							line_acc = times33_plus(line_acc, {56'd0, c});
					end
					nlbh_pkg::MODE_COLLAPSE: begin
						if (!blank)
							line_acc = times33_plus(line_acc, {56'd0, c});
						else if (!prev_blank)
							line_acc = times33_plus(line_acc, {56'd0, nlbh_pkg::SPACE_CHAR});
					end
					default: begin
						line_acc = times33_plus(line_acc, {56'd0, c});
					end
				endcase
				prev_blank = blank;
				if (!blank)
					kept_acc = line_acc;
			end
			nlbh_pkg::OP_LINE_END, nlbh_pkg::OP_BLOCK_END: begin
				due.line_digest = (space_mode == nlbh_pkg::MODE_TRAILING) ? kept_acc : line_acc;
				block_acc = times33_plus(block_acc, due.line_digest);
				due.block_hash = block_acc;
				due.alnum_total = alnum_count;
				due.meets_minimum = (alnum_count >= min_alnum);
				due.block_done = (op == nlbh_pkg::OP_BLOCK_END);
				due_hashes.push_back(due);
				clear_line();
				if (op == nlbh_pkg::OP_BLOCK_END)
					clear_block();
			end
			default: begin
			end
		endcase
	endfunction

	task report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task check_result(input logic [63:0] line_digest, input logic [63:0] block_hash,
		input logic [23:0] alnum_total, input logic meets_minimum, input logic block_done);
		nlbh_pkg::result_t due;
		if (due_hashes.size() == 0) begin
			report_mismatch($sformatf("result with no line end waiting, line_digest %h",
				line_digest));
			return;
		end
		due = due_hashes.pop_front();
		if (line_digest !== due.line_digest)
			report_mismatch($sformatf("line_digest %h, expected %h", line_digest,
				due.line_digest));
		if (block_hash !== due.block_hash)
			report_mismatch($sformatf("block_hash %h, expected %h", block_hash,
				due.block_hash));
		if (alnum_total !== due.alnum_total)
			report_mismatch($sformatf("alnum_total %0d, expected %0d", alnum_total,
				due.alnum_total));
		if (meets_minimum !== due.meets_minimum)
			report_mismatch($sformatf("meets_minimum %b, expected %b", meets_minimum,
				due.meets_minimum));
		if (block_done !== due.block_done)
			report_mismatch($sformatf("block_done %b, expected %b", block_done,
				due.block_done));
	endtask
endclass

module normalized_line_block_hash_tb;
	import nlbh_pkg::*;

	// The block has no name for the fourth operation code; it must be ignored.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 140;
	// Byte requests still in the pipeline when the last result arrives get time to land.
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;

	nlbh_text_if   text_chan();
	nlbh_result_if result_chan();

	normalized_line_block_hash uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_chan(text_chan),
		.result_chan(result_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	line_digest_tracker hashes;

	// Sender pacing: requests go out in bursts, with a random gap between bursts
	// unless the current phase runs the sender without any gaps.
	int burst_left = 0;
	bit steady_sender = 1'b0;

	// Receiver pacing: rx_cycle counts falling edges and paces when the stall style is redrawn at random.
	int rx_cycle = 0;
	int rx_style = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver decides its ready at each falling edge. Style 0 never stalls,
	// styles 1 and 2 stall lightly and heavily at random, and style 3 follows a
	// fixed repeating pattern so that stalls line up with every pipeline phase.
	always @(negedge clk) begin
		if (rx_cycle % 300 == 0)
			rx_style = $urandom_range(0, 3);
		case (rx_style)
			0: result_chan.ready = 1'b1;
			1: result_chan.ready = ($urandom_range(0, 3) != 0);
			2: result_chan.ready = ($urandom_range(0, 3) == 0);
			default: result_chan.ready = ((rx_cycle % 8) < 5);
		endcase
		rx_cycle++;
	end

	// Every result accepted at a rising edge is compared with the oldest line end
	// still owed.
	always @(posedge clk) begin
		if (arst_n && result_chan.valid && result_chan.ready)
			hashes.check_result(result_chan.line_digest, result_chan.block_hash,
				result_chan.alnum_total, result_chan.meets_minimum, result_chan.block_done);
	end

	// Offer one request and hold it until the block takes it. Before a new burst
	// the sender may drop valid for a random gap. Valid is never lowered between
	// two requests of one burst, so the next call simply drives the new fields.
	task automatic send_request(input logic [1:0] op, input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = steady_sender ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				text_chan.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		text_chan.valid = 1'b1;
		text_chan.operation = op;
		text_chan.text_byte = c;
		do
			@(posedge clk);
		while (!text_chan.ready);
		hashes.note_request(op, c);
	endtask

	// Stop sending and wait until every owed result has arrived and the bytes
	// behind it have had time to pass through.
	task automatic settle_block();
		@(negedge clk);
		text_chan.valid = 1'b0;
		burst_left = 0;
		while (hashes.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input logic [23:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		hashes.set_register(index, data);
	endtask

	// Text-like bytes: letters and digits most often, a good share of whitespace so
	// that runs of it form, and some bytes drawn from the whole range.
	function automatic logic [7:0] pick_text_byte();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: return 8'($urandom_range(8'h61, 8'h7a));
			2: return 8'($urandom_range(8'h41, 8'h5a));
			3: return 8'($urandom_range(8'h30, 8'h39));
			4, 5, 6: begin
				pick = $urandom_range(0, 6);
				return (pick == 6) ? 8'h20 : 8'(9 + pick);
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_line_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
	endfunction

	// Mostly well-formed lines with random content, with ignored requests
	// sprinkled in. A phase stops when its budget runs out, often in the middle
	// of a line, so the next setting takes over partway through that line.
	task automatic run_phase(input int budget);
		int sent;
		int line_left;
		sent = 0;
		line_left = pick_line_length();
		while (sent < budget) begin
			if ($urandom_range(0, 19) == 0) begin
				send_request(OP_UNUSED, 8'($urandom_range(0, 255)));
			end else if (line_left > 0) begin
				send_request(OP_BYTE, pick_text_byte());
				line_left--;
				sent++;
			end else begin
				send_request(($urandom_range(0, 4) == 0) ? OP_BLOCK_END : OP_LINE_END,
					8'($urandom_range(0, 255)));
				line_left = pick_line_length();
				sent++;
			end
		end
	endtask

	initial begin
		logic [1:0]  mode;
		logic [23:0] junk;
		logic [23:0] minimum;
		hashes = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPACE_MODE;
		cfg_data = '0;
		text_chan.valid = 1'b0;
		text_chan.operation = OP_BYTE;
		text_chan.text_byte = 8'h00;
		result_chan.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings: byte extremes, the edges of the
		// whitespace range, letters and digits, an ignored request, a line end
		// with a stray byte, and an empty line closing the block.
		send_request(OP_BYTE, 8'h00);
		send_request(OP_BYTE, 8'hFF);
		send_request(OP_BYTE, "a");
		send_request(OP_BYTE, "Z");
		send_request(OP_BYTE, "9");
		send_request(OP_BYTE, 8'h08);
		send_request(OP_BYTE, 8'h09);
		send_request(OP_BYTE, 8'h0d);
		send_request(OP_BYTE, 8'h0e);
		send_request(OP_BYTE, 8'h20);
		send_request(OP_UNUSED, "A");
		send_request(OP_LINE_END, 8'hAA);
		send_request(OP_BLOCK_END, 8'h55);

		// Collapse mode with the smallest minimum, then a switch to the
		// trailing-drop mode and the largest minimum in the middle of a line.
		settle_block();
		write_register(REG_SPACE_MODE, {22'h3FFFFF, MODE_COLLAPSE});
		write_register(REG_MIN_ALNUM, 24'd0);
		send_request(OP_BYTE, 8'h20);
		send_request(OP_BYTE, 8'h09);
		send_request(OP_BYTE, "x");
		send_request(OP_BYTE, 8'h20);
		send_request(OP_BYTE, 8'h20);
		settle_block();
		write_register(REG_SPACE_MODE, {22'd0, MODE_TRAILING});
		write_register(REG_MIN_ALNUM, 24'hFFFFFF);
		send_request(OP_BYTE, "y");
		send_request(OP_BYTE, 8'h0a);
		send_request(OP_BYTE, 8'h20);
		send_request(OP_BLOCK_END, 8'h00);

		// Random phases. The first four walk through every mode and both extremes
		// of the minimum; later ones pick settings at random.
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			junk = 24'($urandom());
			write_register(REG_SPACE_MODE, {junk[23:2], mode});
			if (phase == 0)
				minimum = 24'd0;
			else if (phase == 1)
				minimum = 24'hFFFFFF;
			else begin
				case ($urandom_range(0, 3))
					0: minimum = 24'd0;
					1: minimum = 24'hFFFFFF;
					2: minimum = 24'($urandom_range(0, 80));
					default: minimum = 24'($urandom());
				endcase
			end
			write_register(REG_MIN_ALNUM, minimum);
			steady_sender = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_ITEMS);
		end

		settle_block();
		repeat (END_CYCLES) @(posedge clk);
		if (hashes.mismatch_count == 0)
			$display("normalized_line_block_hash_tb: done, clean");
		else
			$display("normalized_line_block_hash_tb: done, errors");
		$finish;
	end

	// A hang anywhere, including results that never come, ends the run here.
	initial begin
		#2000000;
		$display("normalized_line_block_hash_tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
hdl/nlbh_pkg.sv
hdl/nlbh_if.sv
hdl/nlbh_line_unit.sv
hdl/nlbh_block_unit.sv
hdl/normalized_line_block_hash.sv
tb/sv/normalized_line_block_hash_tb.sv
